>>> hdl/mcg_pkg.sv
package mcg_pkg;

    localparam int MONTH_W    = 4;
    localparam int YEAR_W     = 14;
    localparam int DAY_W      = 5;
    localparam int KIND_W     = 2;
    localparam int MASK_W     = 7;
    localparam int WDAY_W     = 3;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 14;

    localparam int GRID_CELLS = 42;
    localparam int WEEK       = 7;
    localparam int MONTHS     = 12;
    localparam int YEAR_MIN   = 1602;
    localparam int YEAR_MAX   = 9998;

    localparam int TODAY_DAY_RST   = 1;
    localparam int TODAY_MONTH_RST = 1;
    localparam int TODAY_YEAR_RST  = 2000;
    localparam int FREE_MASK_RST   = 96;

    // Division by 25 through a reciprocal, exact for dividends below 2^12.
    localparam int RECIP25    = 2622;
    localparam int RECIP25_SH = 16;
    localparam int P25_W      = YEAR_W - 2 + 12;
    localparam int Q25_W      = P25_W - RECIP25_SH;

    // Division by 7 through a reciprocal, exact for the weekday sum range.
    localparam int SUM_W      = 15;
    localparam int RECIP7     = 37450;
    localparam int RECIP7_SH  = 18;
    localparam int P7_W       = SUM_W + 16;
    localparam int Q7_W       = P7_W - RECIP7_SH;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_TODAY_DAY   = 2'd0,
        CFG_TODAY_MONTH = 2'd1,
        CFG_TODAY_YEAR  = 2'd2,
        CFG_FREE_MASK   = 2'd3
    } t_cfg_idx;

    typedef enum logic [KIND_W-1:0] {
        KIND_OTHER = 2'd0,
        KIND_SHOWN = 2'd1,
        KIND_TODAY = 2'd2
    } t_kind;

    typedef struct packed {
        logic [DAY_W-1:0]   day;
        logic [MONTH_W-1:0] month;
        logic [YEAR_W-1:0]  year;
        logic [MASK_W-1:0]  free_mask;
    } t_today;

    typedef struct packed {
        logic [MONTH_W-1:0] month;
        logic [YEAR_W-1:0]  year;
        logic [MONTH_W-1:0] prev_month;
        logic [YEAR_W-1:0]  prev_year;
        logic [MONTH_W-1:0] next_month;
        logic [YEAR_W-1:0]  next_year;
        logic [WDAY_W-1:0]  first;
        logic [DAY_W-1:0]   cur_len;
        logic [DAY_W-1:0]   prev_day;
    } t_desc;

    function automatic logic [DAY_W-1:0] days_in(input logic [MONTH_W-1:0] month,
                                                 input logic leap);
        logic [DAY_W-1:0] len;
        unique case (month)
            4'd2:                      len = leap ? 5'd29 : 5'd28;
            4'd4, 4'd6, 4'd9, 4'd11:   len = 5'd30;
            default:                   len = 5'd31;
        endcase
        return len;
    endfunction

    // Month offsets of the weekday congruence, indexed by month 1 to 12.
    function automatic logic [WDAY_W-1:0] month_offset(input logic [MONTH_W-1:0] month);
        logic [WDAY_W-1:0] ofs;
        unique case (month)
            4'd2:           ofs = 3'd3;
            4'd3:           ofs = 3'd2;
            4'd4:           ofs = 3'd5;
            4'd6:           ofs = 3'd3;
            4'd7:           ofs = 3'd5;
            4'd8:           ofs = 3'd1;
            4'd9:           ofs = 3'd4;
            4'd10:          ofs = 3'd6;
            4'd11:          ofs = 3'd2;
            4'd12:          ofs = 3'd4;
            default:        ofs = 3'd0;
        endcase
        return ofs;
    endfunction

endpackage

>>> hdl/mcg_if.sv
interface mcg_req_if;
    import mcg_pkg::*;
    logic               valid;
    logic               ready;
    logic [MONTH_W-1:0] show_month;
    logic [YEAR_W-1:0]  show_year;

    modport source(output valid, show_month, show_year, input ready);
    modport sink(input valid, show_month, show_year, output ready);
endinterface

interface mcg_cell_if;
    import mcg_pkg::*;
    logic               valid;
    logic               ready;
    logic [DAY_W-1:0]   cell_day;
    logic [MONTH_W-1:0] cell_month;
    logic [YEAR_W-1:0]  cell_year;
    logic [KIND_W-1:0]  cell_kind;
    logic               cell_free;
    logic               cell_last;

    modport source(output valid, cell_day, cell_month, cell_year, cell_kind, cell_free,
                   cell_last, input ready);
    modport sink(input valid, cell_day, cell_month, cell_year, cell_kind, cell_free,
                 cell_last, output ready);
endinterface

interface mcg_cfg_if;
    import mcg_pkg::*;
    logic                  valid;
    logic                  ready;
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] data;

    modport source(output valid, index, data, input ready);
    modport sink(input valid, index, data, output ready);
endinterface

>>> hdl/mcg_cfg.sv
module mcg_cfg (
    input  logic            i_clk,
    input  logic            i_rst_n,
    mcg_cfg_if.sink         i_cfg,
    output mcg_pkg::t_today o_today
);
    import mcg_pkg::*;

    t_today r_today;
    t_cfg_idx w_idx;

    assign i_cfg.ready = 1'b1;
    assign w_idx = t_cfg_idx'(i_cfg.index);
    assign o_today = r_today;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_today.day       <= DAY_W'(TODAY_DAY_RST);
            r_today.month     <= MONTH_W'(TODAY_MONTH_RST);
            r_today.year      <= YEAR_W'(TODAY_YEAR_RST);
            r_today.free_mask <= MASK_W'(FREE_MASK_RST);
        end else if (i_cfg.valid) begin
            unique case (w_idx)
                CFG_TODAY_DAY:   r_today.day       <= i_cfg.data[DAY_W-1:0];
                CFG_TODAY_MONTH: r_today.month     <= i_cfg.data[MONTH_W-1:0];
                CFG_TODAY_YEAR:  r_today.year      <= i_cfg.data[YEAR_W-1:0];
                CFG_FREE_MASK:   r_today.free_mask <= i_cfg.data[MASK_W-1:0];
            endcase
        end
    end

endmodule

>>> hdl/mcg_front.sv
module mcg_front (
    input  logic           i_clk,
    input  logic           i_rst_n,
    mcg_req_if.sink        i_req,
    output logic           o_desc_valid,
    output mcg_pkg::t_desc o_desc,
    input  logic           i_desc_take
);
    import mcg_pkg::*;

    localparam int NSTG = 5;

    logic [NSTG:1] r_v;
    logic [NSTG+1:1] w_en;

    always_comb begin
        w_en[NSTG+1] = i_desc_take;
        for (int k = NSTG; k >= 1; k--) begin
            w_en[k] = !r_v[k] || w_en[k+1];
        end
    end

    assign i_req.ready = w_en[1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else begin
            if (w_en[1]) r_v[1] <= i_req.valid;
            for (int k = 2; k <= NSTG; k++) begin
                if (w_en[k]) r_v[k] <= r_v[k-1];
            end
        end
    end

    // Stage 1: clamp the request, neighbor months, year used for the weekday sum.
    logic [MONTH_W-1:0] n1_m, n1_pm, n1_nm;
    logic [YEAR_W-1:0]  n1_y, n1_py, n1_ny, n1_yy;
    logic [MONTH_W-1:0] r1_m, r1_pm, r1_nm;
    logic [YEAR_W-1:0]  r1_y, r1_py, r1_ny, r1_yy;

    always_comb begin
        if (i_req.show_month == '0) begin
            n1_m = MONTH_W'(1);
        end else if (i_req.show_month > MONTH_W'(MONTHS)) begin
            n1_m = MONTH_W'(MONTHS);
        end else begin
            n1_m = i_req.show_month;
        end
        if (i_req.show_year < YEAR_W'(YEAR_MIN)) begin
            n1_y = YEAR_W'(YEAR_MIN);
        end else if (i_req.show_year > YEAR_W'(YEAR_MAX)) begin
            n1_y = YEAR_W'(YEAR_MAX);
        end else begin
            n1_y = i_req.show_year;
        end
        n1_pm = (n1_m == MONTH_W'(1)) ? MONTH_W'(MONTHS) : n1_m - MONTH_W'(1);
        n1_py = (n1_m == MONTH_W'(1)) ? n1_y - YEAR_W'(1) : n1_y;
        n1_nm = (n1_m == MONTH_W'(MONTHS)) ? MONTH_W'(1) : n1_m + MONTH_W'(1);
        n1_ny = (n1_m == MONTH_W'(MONTHS)) ? n1_y + YEAR_W'(1) : n1_y;
        n1_yy = (n1_m < MONTH_W'(3)) ? n1_y - YEAR_W'(1) : n1_y;
    end

    always_ff @(posedge i_clk) begin
        if (w_en[1]) begin
            r1_m <= n1_m; r1_pm <= n1_pm; r1_nm <= n1_nm;
            r1_y <= n1_y; r1_py <= n1_py; r1_ny <= n1_ny; r1_yy <= n1_yy;
        end
    end

    // Stage 2: centuries of both years through the reciprocal of 25.
    logic [P25_W-1:0]   n2_pa, n2_pc;
    logic [Q25_W-1:0]   r2_qa, r2_qc;
    logic [MONTH_W-1:0] r2_m, r2_pm, r2_nm;
    logic [YEAR_W-1:0]  r2_y, r2_py, r2_ny, r2_yy;

    assign n2_pa = P25_W'(r1_yy[YEAR_W-1:2]) * P25_W'(RECIP25);
    assign n2_pc = P25_W'(r1_y[YEAR_W-1:2]) * P25_W'(RECIP25);

    always_ff @(posedge i_clk) begin
        if (w_en[2]) begin
            r2_qa <= n2_pa[P25_W-1:RECIP25_SH];
            r2_qc <= n2_pc[P25_W-1:RECIP25_SH];
            r2_m <= r1_m; r2_pm <= r1_pm; r2_nm <= r1_nm;
            r2_y <= r1_y; r2_py <= r1_py; r2_ny <= r1_ny; r2_yy <= r1_yy;
        end
    end

    // Stage 3: weekday sum and the leap year flag of the shown year.
    logic [SUM_W-1:0]    n3_s;
    logic [YEAR_W-3:0]   n3_c25;
    logic                n3_leap;
    logic [SUM_W-1:0]    r3_s;
    logic                r3_leap;
    logic [MONTH_W-1:0]  r3_m, r3_pm, r3_nm;
    logic [YEAR_W-1:0]   r3_y, r3_py, r3_ny;

    always_comb begin
        n3_s = SUM_W'(r2_yy) + SUM_W'(r2_yy[YEAR_W-1:2]) - SUM_W'(r2_qa)
             + SUM_W'(r2_qa[Q25_W-1:2]) + SUM_W'(month_offset(r2_m)) + SUM_W'(1);
        n3_c25 = (YEAR_W-2)'({r2_qc, 4'b0}) + (YEAR_W-2)'({r2_qc, 3'b0})
               + (YEAR_W-2)'(r2_qc);
        n3_leap = (r2_y[1:0] == 2'b00)
               && ((r2_y[YEAR_W-1:2] != n3_c25) || (r2_qc[1:0] == 2'b00));
    end

    always_ff @(posedge i_clk) begin
        if (w_en[3]) begin
            r3_s <= n3_s; r3_leap <= n3_leap;
            r3_m <= r2_m; r3_pm <= r2_pm; r3_nm <= r2_nm;
            r3_y <= r2_y; r3_py <= r2_py; r3_ny <= r2_ny;
        end
    end

    // Stage 4: quotient of the sum by 7.
    logic [P7_W-1:0]    n4_p;
    logic [Q7_W-1:0]    r4_q;
    logic [SUM_W-1:0]   r4_s;
    logic               r4_leap;
    logic [MONTH_W-1:0] r4_m, r4_pm, r4_nm;
    logic [YEAR_W-1:0]  r4_y, r4_py, r4_ny;

    assign n4_p = P7_W'(r3_s) * P7_W'(RECIP7);

    always_ff @(posedge i_clk) begin
        if (w_en[4]) begin
            r4_q <= n4_p[P7_W-1:RECIP7_SH];
            r4_s <= r3_s; r4_leap <= r3_leap;
            r4_m <= r3_m; r4_pm <= r3_pm; r4_nm <= r3_nm;
            r4_y <= r3_y; r4_py <= r3_py; r4_ny <= r3_ny;
        end
    end

    // Stage 5: Monday-based weekday of the first and the month lengths.
    logic [SUM_W-1:0]  n5_rem;
    logic [WDAY_W-1:0] n5_sun, n5_first;
    logic [DAY_W-1:0]  n5_prev_len;
    t_desc             n5_desc, r5_desc;

    always_comb begin
        n5_rem = r4_s - (SUM_W'({r4_q, 3'b0}) - SUM_W'(r4_q));
        n5_sun = n5_rem[WDAY_W-1:0];
        n5_first = (n5_sun == '0) ? WDAY_W'(WEEK - 1) : n5_sun - WDAY_W'(1);
        n5_prev_len = days_in(r4_pm, r4_leap);
        n5_desc.month      = r4_m;
        n5_desc.year       = r4_y;
        n5_desc.prev_month = r4_pm;
        n5_desc.prev_year  = r4_py;
        n5_desc.next_month = r4_nm;
        n5_desc.next_year  = r4_ny;
        n5_desc.first      = n5_first;
        n5_desc.cur_len    = days_in(r4_m, r4_leap);
        n5_desc.prev_day   = n5_prev_len - DAY_W'(n5_first) + DAY_W'(1);
    end

    always_ff @(posedge i_clk) begin
        if (w_en[5]) r5_desc <= n5_desc;
    end

    assign o_desc_valid = r_v[NSTG];
    assign o_desc = r5_desc;

endmodule

>>> hdl/mcg_gen.sv
module mcg_gen #(
    parameter int GRID_CELLS = mcg_pkg::GRID_CELLS
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_desc_valid,
    input  mcg_pkg::t_desc  i_desc,
    output logic            o_desc_take,
    input  mcg_pkg::t_today i_today,
    mcg_cell_if.source      o_cell
);
    import mcg_pkg::*;

    localparam int IW = $clog2(GRID_CELLS);
    localparam int CW = IW + 1;
    localparam logic [IW-1:0] LAST = IW'(GRID_CELLS - 1);

    logic               r_busy;
    logic [IW-1:0]      r_idx;
    logic [WDAY_W-1:0]  r_col;
    t_desc              r_desc;

    logic               r_ovld;
    logic [DAY_W-1:0]   r_day;
    logic [MONTH_W-1:0] r_month;
    logic [YEAR_W-1:0]  r_year;
    t_kind              r_kind;
    logic               r_free;
    logic               r_last;

    logic               w_step, w_end;
    logic [CW-1:0]      w_idx, w_first, w_bound, w_day;
    logic [DAY_W-1:0]   n_day;
    logic [MONTH_W-1:0] n_month;
    logic [YEAR_W-1:0]  n_year;
    t_kind              n_kind;

    // A cell moves to the output word whenever that word is empty or being taken.
    assign w_step = r_busy && (!r_ovld || o_cell.ready);
    assign w_end = w_step && (r_idx == LAST);
    assign o_desc_take = !r_busy || w_end;

    always_comb begin
        w_idx   = CW'(r_idx);
        w_first = CW'(r_desc.first);
        w_bound = w_first + CW'(r_desc.cur_len);
        if (w_idx < w_first) begin
            w_day   = CW'(r_desc.prev_day) + w_idx;
            n_month = r_desc.prev_month;
            n_year  = r_desc.prev_year;
            n_kind  = KIND_OTHER;
        end else if (w_idx < w_bound) begin
            w_day   = w_idx - w_first + CW'(1);
            n_month = r_desc.month;
            n_year  = r_desc.year;
            n_kind  = KIND_SHOWN;
        end else begin
            w_day   = w_idx - w_bound + CW'(1);
            n_month = r_desc.next_month;
            n_year  = r_desc.next_year;
            n_kind  = KIND_OTHER;
        end
        n_day = w_day[DAY_W-1:0];
        if (n_kind == KIND_SHOWN && n_day == i_today.day
            && n_month == i_today.month && n_year == i_today.year) begin
            n_kind = KIND_TODAY;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_idx  <= '0;
            r_col  <= '0;
            r_ovld <= 1'b0;
        end else begin
            if (o_desc_take && i_desc_valid) begin
                r_busy <= 1'b1;
                r_idx  <= '0;
                r_col  <= '0;
            end else if (w_end) begin
                r_busy <= 1'b0;
            end else if (w_step) begin
                r_idx <= r_idx + IW'(1);
                r_col <= (r_col == WDAY_W'(WEEK - 1)) ? '0 : r_col + WDAY_W'(1);
            end
            if (w_step) begin
                r_ovld <= 1'b1;
            end else if (o_cell.ready) begin
                r_ovld <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_desc_take && i_desc_valid) r_desc <= i_desc;
        if (w_step) begin
            r_day   <= n_day;
            r_month <= n_month;
            r_year  <= n_year;
            r_kind  <= n_kind;
            r_free  <= i_today.free_mask[r_col];
            r_last  <= (r_idx == LAST);
        end
    end

    assign o_cell.valid      = r_ovld;
    assign o_cell.cell_day   = r_day;
    assign o_cell.cell_month = r_month;
    assign o_cell.cell_year  = r_year;
    assign o_cell.cell_kind  = r_kind;
    assign o_cell.cell_free  = r_free;
    assign o_cell.cell_last  = r_last;

endmodule

>>> hdl/month_calendar_grid.sv
// Monday-first Gregorian month grid. Each request word (show_month, show_year) yields 42 cell
// words in row order, seven per week row, holding the trailing days of the previous month,
// every day of the shown month and the leading days of the next one; out-of-range months and
// years are clamped to 1..12 and 1602..9998. A cell of the shown month that matches the
// configured today date has kind 2, and cell_free copies the mask bit of the cell's column.
// The weekday of the first is worked out in a five-stage pipeline, followed by the sequencer's
// descriptor register and the output register that holds the cell word. The cell sequencer
// then delivers one cell per cycle while the output is ready, and the next request can wait
// fully computed so its cells follow with no gap. Write the configuration registers only
// while no request is in flight.
module month_calendar_grid #(
    parameter int GRID_CELLS = mcg_pkg::GRID_CELLS
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    mcg_cfg_if.sink    i_cfg,
    mcg_req_if.sink    i_req,
    mcg_cell_if.source o_cell
);
    import mcg_pkg::*;

    t_today w_today;
    t_desc  w_desc;
    logic   w_desc_valid;
    logic   w_desc_take;

    mcg_cfg u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (i_cfg),
        .o_today (w_today)
    );

    mcg_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_req        (i_req),
        .o_desc_valid (w_desc_valid),
        .o_desc       (w_desc),
        .i_desc_take  (w_desc_take)
    );

    mcg_gen #(
        .GRID_CELLS (GRID_CELLS)
    ) u_gen (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_desc_valid (w_desc_valid),
        .i_desc       (w_desc),
        .o_desc_take  (w_desc_take),
        .i_today      (w_today),
        .o_cell       (o_cell)
    );

endmodule

>>> test/tb_month_calendar_grid.sv
`timescale 1ns / 100ps

module tb_month_calendar_grid;
    import mcg_pkg::*;

    localparam int CYCLE_LIMIT = 600000;
    localparam int HOLD_CYCLES = 400;
    localparam int HOLD_AFTER  = 3000;
    localparam int N_DIRECTED  = 21;
    localparam int RAND_PHASES = 4;
    localparam int PHASE_ITEMS = 60;

    typedef struct packed {
        logic [DAY_W-1:0]   day;
        logic [MONTH_W-1:0] month;
        logic [YEAR_W-1:0]  year;
        t_kind              kind;
        logic               free;
        logic               is_last;
    } t_cell;

    // A row with typed set carries the date of the top-left cell of the grid.
    typedef struct packed {
        logic [MONTH_W-1:0] month;
        logic [YEAR_W-1:0]  year;
        logic               typed;
        logic [DAY_W-1:0]   day0;
        logic [MONTH_W-1:0] month0;
        logic [YEAR_W-1:0]  year0;
    } t_req_row;

    localparam t_req_row DIRECTED_ROWS [N_DIRECTED] = '{
        '{4'd1,  14'd2000,  1'b1, 5'd27, 4'd12, 14'd1999},
        '{4'd0,  14'd2000,  1'b1, 5'd27, 4'd12, 14'd1999},
        '{4'd15, 14'd2024,  1'b1, 5'd25, 4'd11, 14'd2024},
        '{4'd1,  14'd2024,  1'b1, 5'd1,  4'd1,  14'd2024},
        '{4'd2,  14'd2021,  1'b1, 5'd1,  4'd2,  14'd2021},
        '{4'd10, 14'd2023,  1'b1, 5'd25, 4'd9,  14'd2023},
        '{4'd3,  14'd0,     1'b0, 5'd0,  4'd0,  14'd0},
        '{4'd6,  14'h3FFF,  1'b0, 5'd0,  4'd0,  14'd0},
        '{4'd1,  14'd1602,  1'b0, 5'd0,  4'd0,  14'd0},
        '{4'd12, 14'd9998,  1'b0, 5'd0,  4'd0,  14'd0},
        '{4'd2,  14'd2000,  1'b0, 5'd0,  4'd0,  14'd0},
        '{4'd2,  14'd1900,  1'b0, 5'd0,  4'd0,  14'd0},
        '{4'd2,  14'd2100,  1'b0, 5'd0,  4'd0,  14'd0},
        '{4'd2,  14'd2023,  1'b0, 5'd0,  4'd0,  14'd0},
        '{4'd4,  14'd2024,  1'b0, 5'd0,  4'd0,  14'd0},
        '{4'd5,  14'd2019,  1'b0, 5'd0,  4'd0,  14'd0},
        '{4'd7,  14'd2033,  1'b0, 5'd0,  4'd0,  14'd0},
        '{4'd8,  14'd4000,  1'b0, 5'd0,  4'd0,  14'd0},
        '{4'd9,  14'd1752,  1'b0, 5'd0,  4'd0,  14'd0},
        '{4'd11, 14'd7777,  1'b0, 5'd0,  4'd0,  14'd0},
        '{4'd13, 14'd1601,  1'b0, 5'd0,  4'd0,  14'd0}
    };

    logic i_clk = 1'b0;
    logic i_rst_n;

    mcg_req_if  req_if();
    mcg_cfg_if  cfg_if();
    mcg_cell_if cell_if();

    month_calendar_grid u_dut (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_cfg  (cfg_if),
        .i_req  (req_if),
        .o_cell (cell_if)
    );

    always #2 i_clk = ~i_clk;

    // Mirror of the configuration registers.
    logic [DAY_W-1:0]   today_day;
    logic [MONTH_W-1:0] today_month;
    logic [YEAR_W-1:0]  today_year;
    logic [MASK_W-1:0]  free_mask;

    t_cell expected_cells[$];

    int mismatches    = 0;
    int cells_seen    = 0;
    int today_cells   = 0;
    int grids_sent    = 0;
    int settings_done = 0;
    int burst_left    = 0;
    int cycle_count   = 0;

    function automatic int days_of_month(int m, int y);
        bit leap;
        leap = (y % 4 == 0) && ((y % 100 != 0) || (y % 400 == 0));
        case (m)
            2:             return leap ? 29 : 28;
            4, 6, 9, 11:   return 30;
            default:       return 31;
        endcase
    endfunction

    // Running day count with the year starting in March, so leap days fall at the end.
    function automatic int day_number(int y, int m, int d);
        int mm;
        int yy;
        mm = (m + 9) % 12;
        yy = y - mm / 10;
        return 365 * yy + yy / 4 - yy / 100 + yy / 400 + (mm * 306 + 5) / 10 + d - 1;
    endfunction

    // 0 is Monday; 1 January 2024 was a Monday.
    function automatic int weekday_of(int y, int m, int d);
        int diff;
        diff = day_number(y, m, d) - day_number(2024, 1, 1);
        return ((diff % 7) + 7) % 7;
    endfunction

    function automatic void predict_month_grid(logic [MONTH_W-1:0] show_month,
                                               logic [YEAR_W-1:0] show_year);
        int m;
        int y;
        int pm;
        int py;
        int nm;
        int ny;
        int lead;
        int len;
        int plen;
        t_cell c;
        m = show_month;
        y = show_year;
        if (m < 1) m = 1;
        if (m > MONTHS) m = MONTHS;
        if (y < YEAR_MIN) y = YEAR_MIN;
        if (y > YEAR_MAX) y = YEAR_MAX;
        pm = (m == 1) ? MONTHS : m - 1;
        py = (m == 1) ? y - 1 : y;
        nm = (m == MONTHS) ? 1 : m + 1;
        ny = (m == MONTHS) ? y + 1 : y;
        lead = weekday_of(y, m, 1);
        len  = days_of_month(m, y);
        plen = days_of_month(pm, py);
        for (int i = 0; i < GRID_CELLS; i++) begin
            if (i < lead) begin
                c.day   = DAY_W'(plen - lead + 1 + i);
                c.month = MONTH_W'(pm);
                c.year  = YEAR_W'(py);
                c.kind  = KIND_OTHER;
            end else if (i < lead + len) begin
                c.day   = DAY_W'(i - lead + 1);
                c.month = MONTH_W'(m);
                c.year  = YEAR_W'(y);
                if (i - lead + 1 == int'(today_day) && m == int'(today_month)
                        && y == int'(today_year))
                    c.kind = KIND_TODAY;
                else
                    c.kind = KIND_SHOWN;
            end else begin
                c.day   = DAY_W'(i - lead - len + 1);
                c.month = MONTH_W'(nm);
                c.year  = YEAR_W'(ny);
                c.kind  = KIND_OTHER;
            end
            c.free    = free_mask[i % WEEK];
            c.is_last = (i == GRID_CELLS - 1);
            expected_cells = {expected_cells, c};
        end
    endfunction

    // Called at a falling edge; returns at the falling edge after the word is taken.
    task automatic send_request(input logic [MONTH_W-1:0] m, input logic [YEAR_W-1:0] y);
        if (burst_left == 0) begin
            req_if.valid <= 1'b0;
            repeat ($urandom_range(1, 60)) @(negedge i_clk);
            burst_left = $urandom_range(1, 8);
        end
        req_if.valid      <= 1'b1;
        req_if.show_month <= m;
        req_if.show_year  <= y;
        do @(posedge i_clk); while (!req_if.ready);
        predict_month_grid(m, y);
        grids_sent++;
        burst_left--;
        @(negedge i_clk);
    endtask

    task automatic stop_and_drain();
        req_if.valid <= 1'b0;
        @(negedge i_clk);
        while (expected_cells.size() != 0) @(negedge i_clk);
    endtask

    // Writes the four registers back to back with the write valid held high.
    task automatic write_settings(input logic [CFG_DATA_W-1:0] day_data,
                                  input logic [CFG_DATA_W-1:0] month_data,
                                  input logic [CFG_DATA_W-1:0] year_data,
                                  input logic [CFG_DATA_W-1:0] mask_data);
        t_cfg_idx idx;
        logic [CFG_DATA_W-1:0] data;
        for (int k = 0; k < 4; k++) begin
            idx = t_cfg_idx'(k);
            case (idx)
                CFG_TODAY_DAY:   data = day_data;
                CFG_TODAY_MONTH: data = month_data;
                CFG_TODAY_YEAR:  data = year_data;
                default:         data = mask_data;
            endcase
            cfg_if.valid <= 1'b1;
            cfg_if.index <= idx;
            cfg_if.data  <= data;
            do @(posedge i_clk); while (!cfg_if.ready);
            case (idx)
                CFG_TODAY_DAY:   today_day   = data[DAY_W-1:0];
                CFG_TODAY_MONTH: today_month = data[MONTH_W-1:0];
                CFG_TODAY_YEAR:  today_year  = data[YEAR_W-1:0];
                default:         free_mask   = data[MASK_W-1:0];
            endcase
            @(negedge i_clk);
        end
        cfg_if.valid <= 1'b0;
        settings_done++;
    endtask

    task automatic random_phase();
        int y;
        int m;
        int d;
        int pick;
        logic [CFG_DATA_W-1:0] junk;
        y = $urandom_range(YEAR_MIN, YEAR_MAX);
        m = $urandom_range(1, MONTHS);
        d = $urandom_range(1, days_of_month(m, y));
        junk = CFG_DATA_W'($urandom);
        // Unused upper bits of the narrow registers carry noise.
        write_settings((junk & ~CFG_DATA_W'(31)) | CFG_DATA_W'(d),
                       (junk & ~CFG_DATA_W'(15)) | CFG_DATA_W'(m),
                       CFG_DATA_W'(y),
                       (junk & ~CFG_DATA_W'(127)) | CFG_DATA_W'($urandom_range(0, 127)));
        for (int n = 0; n < PHASE_ITEMS; n++) begin
            pick = $urandom_range(0, 99);
            if (pick < 35)
                send_request(MONTH_W'(m), YEAR_W'(y));
            else if (pick < 50)
                send_request(MONTH_W'($urandom_range(1, MONTHS)), YEAR_W'(y));
            else if (pick < 90)
                send_request(MONTH_W'($urandom_range(1, MONTHS)),
                             YEAR_W'($urandom_range(YEAR_MIN, YEAR_MAX)));
            else
                send_request(MONTH_W'($urandom), YEAR_W'($urandom));
        end
        stop_and_drain();
    endtask

    // Result side: stalls in changing patterns, and once holds off for a long stretch.
    initial begin
        int hold_left;
        int mode;
        int mode_left;
        int tick;
        bit held;
        hold_left = 0;
        mode = 0;
        mode_left = 0;
        tick = 0;
        held = 1'b0;
        cell_if.ready = 1'b0;
        forever begin
            @(negedge i_clk);
            tick++;
            if (!i_rst_n) begin
                cell_if.ready <= 1'b0;
            end else if (hold_left > 0) begin
                cell_if.ready <= 1'b0;
                hold_left--;
            end else if (!held && cells_seen >= HOLD_AFTER) begin
                held = 1'b1;
                hold_left = HOLD_CYCLES - 1;
                cell_if.ready <= 1'b0;
            end else begin
                if (mode_left == 0) begin
                    mode = $urandom_range(0, 3);
                    mode_left = $urandom_range(20, 200);
                end
                mode_left--;
                case (mode)
                    0:       cell_if.ready <= 1'b1;
                    1:       cell_if.ready <= $urandom_range(0, 1);
                    2:       cell_if.ready <= ($urandom_range(0, 3) == 0);
                    default: cell_if.ready <= (tick % 5 != 4);
                endcase
            end
        end
    end

    always @(posedge i_clk) begin
        t_cell exp_cell;
        if (i_rst_n && cell_if.valid && cell_if.ready) begin
            cells_seen++;
            if (expected_cells.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("Cell word %0d arrived with no grid pending", cells_seen);
            end else begin
                exp_cell = expected_cells.pop_front();
                if (exp_cell.kind == KIND_TODAY) today_cells++;
                if (cell_if.cell_day !== exp_cell.day || cell_if.cell_month !== exp_cell.month
                        || cell_if.cell_year !== exp_cell.year
                        || cell_if.cell_kind !== exp_cell.kind
                        || cell_if.cell_free !== exp_cell.free
                        || cell_if.cell_last !== exp_cell.is_last) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display({"Cell %0d: expected %0d/%0d/%0d kind %0d free %0b last %0b,",
                                  " got %0d/%0d/%0d kind %0d free %0b last %0b"},
                                 cells_seen, exp_cell.day, exp_cell.month, exp_cell.year,
                                 exp_cell.kind, exp_cell.free, exp_cell.is_last,
                                 cell_if.cell_day, cell_if.cell_month, cell_if.cell_year,
                                 cell_if.cell_kind, cell_if.cell_free, cell_if.cell_last);
                end
            end
        end
    end

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("Timed out after %0d cycles with %0d cells pending", cycle_count,
                     expected_cells.size());
            $display("FAILED: results differ");
            $finish;
        end
    end

    initial begin
        int first;
        i_rst_n           = 1'b0;
        req_if.valid      = 1'b0;
        req_if.show_month = '0;
        req_if.show_year  = '0;
        cfg_if.valid      = 1'b0;
        cfg_if.index      = CFG_TODAY_DAY;
        cfg_if.data       = '0;
        today_day   = DAY_W'(TODAY_DAY_RST);
        today_month = MONTH_W'(TODAY_MONTH_RST);
        today_year  = YEAR_W'(TODAY_YEAR_RST);
        free_mask   = MASK_W'(FREE_MASK_RST);
        repeat (11) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // Directed grids under the reset settings; 1 January 2000 is today.
        foreach (DIRECTED_ROWS[r]) begin
            send_request(DIRECTED_ROWS[r].month, DIRECTED_ROWS[r].year);
            if (DIRECTED_ROWS[r].typed) begin
                first = expected_cells.size() - GRID_CELLS;
                expected_cells[first].day   = DIRECTED_ROWS[r].day0;
                expected_cells[first].month = DIRECTED_ROWS[r].month0;
                expected_cells[first].year  = DIRECTED_ROWS[r].year0;
            end
        end
        stop_and_drain();

        // A leap day as today: marked in February, left plain as a March lead-in cell.
        write_settings(14'd29, 14'd2, 14'd2024, 14'h7F);
        send_request(4'd2, 14'd2024);
        send_request(4'd3, 14'd2024);
        send_request(4'd2, 14'd2023);
        stop_and_drain();

        // Impossible today dates at both ends never match.
        write_settings(14'h3FFF, 14'h3FFF, 14'h3FFF, 14'h0);
        send_request(4'd15, 14'h3FFF);
        send_request(4'd12, 14'd9998);
        stop_and_drain();
        write_settings(14'h0, 14'h0, 14'h0, 14'h3FFF);
        send_request(4'd0, 14'd0);
        send_request(4'd1, 14'd1602);
        stop_and_drain();

        for (int p = 0; p < RAND_PHASES; p++) random_phase();

        repeat (40) @(posedge i_clk);
        mismatches += expected_cells.size();
        $display("Checked %0d cells of %0d grids under %0d register settings.",
                 cells_seen, grids_sent, settings_done);
        $display("Cells marked today: %0d; long output hold-off applied once.", today_cells);
        if (mismatches == 0)
            $display("PASSED: all results match");
        else
            $display("FAILED: results differ");
        $finish;
    end

endmodule

>>> files.f
hdl/mcg_pkg.sv
hdl/mcg_if.sv
hdl/mcg_cfg.sv
hdl/mcg_front.sv
hdl/mcg_gen.sv
hdl/month_calendar_grid.sv
test/tb_month_calendar_grid.sv
